FILE: sv/gbch_pkg.sv
// ----------------------------------------------------------------------------
// gbch_pkg
// Shared types and constants of the gray brightness/contrast histogram unit.
// ----------------------------------------------------------------------------
package gbch_pkg;

  localparam int LEVEL_W       = 8;
  localparam int NUM_W         = 26;
  localparam int DEN_W         = 15;
  localparam int REM_W         = 23;
  localparam int FIELD_COUNT_W = 20;
  localparam int CFG_INDEX_W   = 1;
  localparam int BIN_INDEX_W   = 7;

  localparam logic [21:0] GRAY_WEIGHT_R = 22'd4899;
  localparam logic [21:0] GRAY_WEIGHT_G = 22'd9617;
  localparam logic [21:0] GRAY_WEIGHT_B = 22'd1868;
  localparam logic [21:0] GRAY_ROUND    = 22'd8192;

  localparam logic [7:0]       SLIDER_MAX = 8'd200;
  localparam logic [7:0]       SLIDER_MID = 8'd100;
  localparam logic [DEN_W-1:0] DEN_BASE   = 15'd25500;

  localparam logic [FIELD_COUNT_W-1:0] FIELD_COUNT_MAX = '1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTRAST   = 1'd1;

  typedef enum logic {
    HIST_INCR,
    HIST_READ_CLEAR
  } hist_op_t;

  typedef struct packed {
    logic     valid;
    hist_op_t op;
  } hist_req_t;

endpackage

FILE: sv/gbch_div.sv
// ----------------------------------------------------------------------------
// gbch_div
// Iterative divider that maps a signed numerator and a positive denominator
// to a level rounded to nearest, ties to even, and clamped to 0..255.
// ----------------------------------------------------------------------------
module gbch_div
  import gbch_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic [LEVEL_W-1:0]      level
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_ITER,
    D_ROUND
  } dstate_t;

  dstate_t              dstate_r;
  logic                 done_r;
  logic [LEVEL_W-1:0]   level_r;
  logic [REM_W-1:0]     rem_r;
  logic [REM_W-1:0]     dsh_r;
  logic [DEN_W-1:0]     den_r;
  logic [LEVEL_W-1:0]   quo_r;
  logic [2:0]           step_r;

  logic [REM_W-1:0]     den_top;
  logic                 over;
  logic                 ge;
  logic [DEN_W:0]       twice_rem;
  logic                 round_up;

  assign den_top   = {den, 8'd0};
  assign over      = num[NUM_W-2:0] >= 25'(den_top);
  assign ge        = rem_r >= dsh_r;
  assign twice_rem = {rem_r[DEN_W-1:0], 1'b0};
  assign round_up  = (twice_rem > {1'b0, den_r}) ||
                     ((twice_rem == {1'b0, den_r}) && quo_r[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
      done_r   <= 1'b0;
    end else begin
      done_r <= (dstate_r == D_ROUND) ||
                ((dstate_r == D_IDLE) && start && (num[NUM_W-1] || over));
      case (dstate_r)
        D_IDLE: begin
          if (start) begin
            if (num[NUM_W-1]) begin
              level_r <= '0;
            end else if (over) begin
              level_r <= '1;
            end else begin
              rem_r    <= num[REM_W-1:0];
              dsh_r    <= {1'b0, den, 7'd0};
              den_r    <= den;
              quo_r    <= '0;
              step_r   <= 3'd7;
              dstate_r <= D_ITER;
            end
          end
        end
        D_ITER: begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          quo_r  <= {quo_r[LEVEL_W-2:0], ge};
          dsh_r  <= dsh_r >> 1;
          step_r <= step_r - 3'd1;
          if (step_r == 3'd0) begin
            dstate_r <= D_ROUND;
          end
        end
        D_ROUND: begin
          if (round_up && (quo_r != '1)) begin
            level_r <= quo_r + 8'd1;
          end else begin
            level_r <= quo_r;
          end
          dstate_r <= D_IDLE;
        end
        default: begin
          dstate_r <= D_IDLE;
        end
      endcase
    end
  end

  assign done  = done_r;
  assign level = level_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (dstate_r == D_IDLE))
    else $error("Divider started while busy.");

endmodule

FILE: sv/gbch_hist.sv
// ----------------------------------------------------------------------------
// gbch_hist
// Histogram counter store: one synchronous memory with per-entry valid bits,
// updated by a registered read-modify-write per request.
// ----------------------------------------------------------------------------
module gbch_hist
  import gbch_pkg::*;
#(
  parameter int BIN_COUNT   = 128,
  parameter int COUNT_WIDTH = 20,
  parameter int AW          = 7
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  hist_req_t              req,
  input  logic [AW-1:0]          addr,
  output logic                   done,
  output logic [COUNT_WIDTH-1:0] count
);

  logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
  logic [BIN_COUNT-1:0]   valid_r;
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic                   hit_r;
  logic                   pend_r;
  hist_op_t               op_r;
  logic [AW-1:0]          addr_r;

  logic [COUNT_WIDTH-1:0] old_count;
  logic [COUNT_WIDTH-1:0] new_count;
  logic                   wr_en;

  assign old_count = hit_r ? rd_data_r : '0;
  assign new_count = (old_count == '1) ? old_count : old_count + 1'b1;
  assign wr_en     = pend_r && (op_r == HIST_INCR);

  always_ff @(posedge clk) begin
    if (req.valid) begin
      rd_data_r <= mem[addr];
    end
    if (wr_en) begin
      mem[addr_r] <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      hit_r  <= valid_r[addr];
      op_r   <= req.op;
      addr_r <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      pend_r <= req.valid;
      if (pend_r) begin
        valid_r[addr_r] <= (op_r == HIST_INCR);
      end
    end
  end

  assign done  = pend_r;
  assign count = old_count;

  assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> !pend_r)
    else $error("Histogram request overlaps a pending update.");

endmodule

FILE: sv/gray_brightness_contrast_histogram_unit.sv
// ----------------------------------------------------------------------------
// gray_brightness_contrast_histogram_unit
// Converts RGB pixels to gray, applies a brightness/contrast map and counts
// the mapped levels in a histogram that can be read and cleared bin by bin.
//
//   Channel  Direction  Handshake              Beat
//   in_      input      in_valid / in_ready    command, pixel, bin index
//   out_     output     out_valid / out_ready  result kind, gray, bin count
//   cfg_     input      cfg_valid / cfg_ready  register index, data
//
// A pixel beat runs the numerator states, the eight-step divider, unless the
// map clamps before division, and the histogram update. A read beat runs the
// histogram read-and-clear, unless the bin index is out of range.
// The histogram memory does one read-modify-write per in-range beat.
// Reset clears the valid bits of all bins at once, so no clearing pass runs.
// The next beat is accepted while a result waits in the output register.
// ----------------------------------------------------------------------------
module gray_brightness_contrast_histogram_unit
  import gbch_pkg::*;
#(
  parameter int BIN_COUNT   = 128,
  parameter int COUNT_WIDTH = 20
)(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic [7:0]               in_pixel_red,
  input  logic [7:0]               in_pixel_green,
  input  logic [7:0]               in_pixel_blue,
  input  logic [BIN_INDEX_W-1:0]   in_bin_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_result_kind,
  output logic [LEVEL_W-1:0]       out_adjusted_gray,
  output logic [FIELD_COUNT_W-1:0] out_bin_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]               cfg_data
);

  localparam int AW    = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int EXT_W = (COUNT_WIDTH > FIELD_COUNT_W) ? COUNT_WIDTH : FIELD_COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NUM1,
    S_NUM2,
    S_START,
    S_DIV,
    S_HIST,
    S_HWAIT,
    S_OUT
  } state_t;

  state_t                     state_r;
  logic [7:0]                 brightness_r;
  logic [7:0]                 contrast_r;
  logic [LEVEL_W-1:0]         gray_r;
  logic signed [16:0]         t_r;
  logic signed [NUM_W-1:0]    n_r;
  logic [DEN_W-1:0]           d_r;
  hist_op_t                   hist_op_r;
  logic [AW-1:0]              hist_addr_r;
  logic                       res_kind_r;
  logic [LEVEL_W-1:0]         res_gray_r;
  logic [FIELD_COUNT_W-1:0]   res_count_r;
  logic                       out_valid_r;
  logic                       out_kind_r;
  logic [LEVEL_W-1:0]         out_gray_r;
  logic [FIELD_COUNT_W-1:0]   out_count_r;

  logic [21:0]                gray_sum;
  logic [7:0]                 bs_clamp;
  logic [7:0]                 cs_clamp;
  logic                       pos;
  logic signed [9:0]          br;
  logic signed [9:0]          x10;
  logic signed [16:0]         x17;
  logic signed [16:0]         c17;
  logic [6:0]                 cpos;
  logic signed [16:0]         t_nxt;
  logic [DEN_W-1:0]           d_nxt;
  logic signed [NUM_W-1:0]    t26;
  logic signed [NUM_W-1:0]    c26;
  logic signed [NUM_W-1:0]    n_nxt;
  logic [8:0]                 idx_ext;
  logic                       idx_ok;
  logic                       div_done;
  logic [LEVEL_W-1:0]         div_level;
  logic [16:0]                bin_prod;
  hist_req_t                  hist_req;
  logic                       hist_done;
  logic [COUNT_WIDTH-1:0]     hist_count;
  logic [EXT_W-1:0]           count_ext;
  logic [FIELD_COUNT_W-1:0]   count_sat;

  assign gray_sum = GRAY_WEIGHT_R * 22'(in_pixel_red) + GRAY_WEIGHT_G * 22'(in_pixel_green)
                  + GRAY_WEIGHT_B * 22'(in_pixel_blue) + GRAY_ROUND;

  assign bs_clamp = (brightness_r > SLIDER_MAX) ? SLIDER_MAX : brightness_r;
  assign cs_clamp = (contrast_r > SLIDER_MAX) ? SLIDER_MAX : contrast_r;
  assign pos      = cs_clamp > SLIDER_MID;
  assign br       = $signed({2'b00, bs_clamp}) - 10'sd100;
  assign x10      = $signed({2'b00, gray_r}) + br;
  assign x17      = {{7{x10[9]}}, x10};
  assign c17      = $signed({9'd0, cs_clamp}) - 17'sd100;
  assign cpos     = 7'(cs_clamp - SLIDER_MID);
  assign t_nxt    = pos ? (x17 * 17'sd100 - c17 * 17'sd127)
                        : (x17 * $signed({9'd0, cs_clamp}));
  assign d_nxt    = pos ? (DEN_BASE - 15'(cpos) * 15'd254) : DEN_BASE;
  assign t26      = {{9{t_r[16]}}, t_r};
  assign c26      = {{9{c17[16]}}, c17};
  assign n_nxt    = pos ? (t26 * 26'sd255) : ((t26 <<< 8) - c26 * 26'sd32640);

  assign idx_ext  = {2'b00, in_bin_index};
  assign idx_ok   = idx_ext < 9'(BIN_COUNT);
  assign bin_prod = 17'(div_level) * 17'(BIN_COUNT);

  assign count_ext = EXT_W'(hist_count);
  assign count_sat = (count_ext > EXT_W'(FIELD_COUNT_MAX)) ? FIELD_COUNT_MAX
                                                            : count_ext[FIELD_COUNT_W-1:0];

  assign hist_req.valid = (state_r == S_HIST);
  assign hist_req.op    = hist_op_r;

  gbch_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_START),
    .num   (n_r),
    .den   (d_r),
    .done  (div_done),
    .level (div_level)
  );

  gbch_hist #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH),
    .AW          (AW)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hist_req),
    .addr  (hist_addr_r),
    .done  (hist_done),
    .count (hist_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= SLIDER_MID;
      contrast_r   <= SLIDER_MID;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BRIGHTNESS: brightness_r <= cfg_data;
        REG_CONTRAST:   contrast_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            gray_r      <= gray_sum[21:14];
            res_gray_r  <= '0;
            res_count_r <= '0;
            if (in_command == CMD_READ) begin
              res_kind_r  <= KIND_BIN;
              hist_op_r   <= HIST_READ_CLEAR;
              hist_addr_r <= AW'(in_bin_index);
              state_r     <= idx_ok ? S_HIST : S_OUT;
            end else begin
              res_kind_r <= KIND_PIXEL;
              hist_op_r  <= HIST_INCR;
              state_r    <= S_NUM1;
            end
          end
        end
        S_NUM1: begin
          t_r     <= t_nxt;
          d_r     <= d_nxt;
          state_r <= S_NUM2;
        end
        S_NUM2: begin
          n_r     <= n_nxt;
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_gray_r  <= div_level;
            hist_addr_r <= AW'(bin_prod >> 8);
            state_r     <= S_HIST;
          end
        end
        S_HIST: begin
          state_r <= S_HWAIT;
        end
        S_HWAIT: begin
          if (hist_done) begin
            if (res_kind_r == KIND_BIN) begin
              res_count_r <= count_sat;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_gray_r  <= res_gray_r;
            out_count_r <= res_count_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_adjusted_gray = out_gray_r;
  assign out_bin_count     = out_count_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Input accepted again before the current beat finished.");

  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("Divider finished outside of the divide state.");

  assert property (@(posedge clk) disable iff (!rst_n)
    hist_done |-> (state_r == S_HWAIT))
    else $error("Histogram update finished outside of its wait state.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_BIN)) |-> (out_adjusted_gray == '0))
    else $error("Bin result carries a nonzero gray level.");

endmodule

FILE: tb/gray_brightness_contrast_histogram_unit_tb.sv
// ----------------------------------------------------------------------------
// gray_brightness_contrast_histogram_unit_tb
// Drives pixel and bin-read beats through the unit with random idling on both
// channels, checking each result beat against a behavioral model of the gray
// conversion, brightness/contrast map and histogram store, or a typed
// value. A directed table leads, then random phases with new slider settings.
// ----------------------------------------------------------------------------
module gray_brightness_contrast_histogram_unit_tb;
  import gbch_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BIN_COUNT     = 128;
  localparam int COUNT_WIDTH   = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 143;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DIRECTED_ROWS = 31;

  typedef struct packed {
    logic                     kind;
    logic [LEVEL_W-1:0]       gray;
    logic [FIELD_COUNT_W-1:0] count;
  } unit_result_t;

  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_READ,
    ROW_CONFIG
  } row_kind_t;

  typedef struct packed {
    row_kind_t            row_kind;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [BIN_INDEX_W-1:0] bin;
    logic [7:0]           brightness;
    logic [7:0]           contrast;
    logic                 typed;
    unit_result_t         result;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_command = CMD_PIXEL;
  logic [7:0]               in_pixel_red = '0;
  logic [7:0]               in_pixel_green = '0;
  logic [7:0]               in_pixel_blue = '0;
  logic [BIN_INDEX_W-1:0]   in_bin_index = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_result_kind;
  logic [LEVEL_W-1:0]       out_adjusted_gray;
  logic [FIELD_COUNT_W-1:0] out_bin_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = REG_BRIGHTNESS;
  logic [7:0]               cfg_data = '0;

  logic [7:0]             brightness_reg = SLIDER_MID;
  logic [7:0]             contrast_reg = SLIDER_MID;
  logic [COUNT_WIDTH-1:0] bin_counts [BIN_COUNT];
  unit_result_t           awaited_results [$];
  unit_result_t           head_result;
  stim_row_t              directed_rows [DIRECTED_ROWS];
  int                     mismatch_count = 0;
  int                     cycle_count = 0;
  int                     send_calm = 0;
  int                     recv_calm = 0;
  bit                     hold_request = 1'b0;

  gray_brightness_contrast_histogram_unit #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_pixel_red     (in_pixel_red),
    .in_pixel_green   (in_pixel_green),
    .in_pixel_blue    (in_pixel_blue),
    .in_bin_index     (in_bin_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_adjusted_gray(out_adjusted_gray),
    .out_bin_count    (out_bin_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic logic [7:0] map_level(logic [7:0] gray);
    longint bs, cs, x, c, num, den, q, rem;
    bs = (brightness_reg > SLIDER_MAX) ? SLIDER_MAX : brightness_reg;
    cs = (contrast_reg > SLIDER_MAX) ? SLIDER_MAX : contrast_reg;
    x = longint'(gray) + bs - 100;
    c = cs - 100;
    if (c > 0) begin
      num = 255 * (100 * x - 127 * c);
      den = 25500 - 254 * c;
    end else begin
      num = (25600 + 256 * c) * x - 32640 * c;
      den = 25500;
    end
    q = num / den;
    rem = num - q * den;
    if (rem < 0) begin
      q--;
      rem += den;
    end
    if (2 * rem > den || (2 * rem == den && q[0])) begin
      q++;
    end
    if (q < 0) begin
      return 8'd0;
    end
    if (q > 255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  function automatic unit_result_t predict_beat_result(logic cmd, logic [7:0] r,
                                                       logic [7:0] g, logic [7:0] b,
                                                       logic [BIN_INDEX_W-1:0] idx);
    unit_result_t res;
    int unsigned  gray;
    int unsigned  bin;
    res = '0;
    if (cmd == CMD_PIXEL) begin
      gray = (4899 * int'(r) + 9617 * int'(g) + 1868 * int'(b) + 8192) >> 14;
      res.kind = KIND_PIXEL;
      res.gray = map_level(gray[7:0]);
      bin = int'(res.gray) * BIN_COUNT / 256;
      if (bin < BIN_COUNT && bin_counts[bin] != '1) begin
        bin_counts[bin]++;
      end
    end else begin
      res.kind = KIND_BIN;
      if (idx < BIN_COUNT) begin
        res.count = (bin_counts[idx] > FIELD_COUNT_MAX) ? FIELD_COUNT_MAX
                                                        : FIELD_COUNT_W'(bin_counts[idx]);
        bin_counts[idx] = '0;
      end
    end
    return res;
  endfunction

  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left = $urandom_range(10, 40);
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] pick_slider();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return SLIDER_MID;
      2: return SLIDER_MAX;
      3: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic stim_row_t px(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    stim_row_t row;
    row = '0;
    row.row_kind = ROW_PIXEL;
    row.red = r;
    row.green = g;
    row.blue = b;
    return row;
  endfunction

  function automatic stim_row_t px_is(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] gray);
    stim_row_t row;
    row = px(r, g, b);
    row.typed = 1'b1;
    row.result.kind = KIND_PIXEL;
    row.result.gray = gray;
    return row;
  endfunction

  function automatic stim_row_t rd(logic [BIN_INDEX_W-1:0] idx);
    stim_row_t row;
    row = '0;
    row.row_kind = ROW_READ;
    row.bin = idx;
    return row;
  endfunction

  function automatic stim_row_t rd_is(logic [BIN_INDEX_W-1:0] idx,
                                      logic [FIELD_COUNT_W-1:0] count);
    stim_row_t row;
    row = rd(idx);
    row.typed = 1'b1;
    row.result.kind = KIND_BIN;
    row.result.count = count;
    return row;
  endfunction

  function automatic stim_row_t cf(logic [7:0] brightness, logic [7:0] contrast);
    stim_row_t row;
    row = '0;
    row.row_kind = ROW_CONFIG;
    row.brightness = brightness;
    row.contrast = contrast;
    return row;
  endfunction

  task automatic send_beat(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [BIN_INDEX_W-1:0] idx, logic typed,
                           unit_result_t typed_result);
    int           gap;
    unit_result_t predicted;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pixel_red <= r;
    in_pixel_green <= g;
    in_pixel_blue <= b;
    in_bin_index <= idx;
    do @(posedge clk); while (!in_ready);
    predicted = predict_beat_result(cmd, r, g, b, idx);
    awaited_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic configure(logic [7:0] brightness, logic [7:0] contrast);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_BRIGHTNESS;
    cfg_data <= brightness;
    do @(posedge clk); while (!cfg_ready);
    brightness_reg = brightness;
    cfg_index <= REG_CONTRAST;
    cfg_data <= contrast;
    do @(posedge clk); while (!cfg_ready);
    contrast_reg = contrast;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        head_result = awaited_results.pop_front();
        if (out_result_kind !== head_result.kind) begin
          report_mismatch($sformatf("result_kind %0d, want %0d",
                                    out_result_kind, head_result.kind));
        end
        if (out_adjusted_gray !== head_result.gray) begin
          report_mismatch($sformatf("adjusted_gray %0d, want %0d",
                                    out_adjusted_gray, head_result.gray));
        end
        if (out_bin_count !== head_result.count) begin
          report_mismatch($sformatf("bin_count %0d, want %0d",
                                    out_bin_count, head_result.count));
        end
      end
    end
  end

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    stim_row_t              row;
    int                     phase;
    int                     n;
    logic [7:0]             r, g, b;
    logic [BIN_INDEX_W-1:0] idx;

    foreach (bin_counts[k]) begin
      bin_counts[k] = '0;
    end
    directed_rows = '{
      rd_is(0, 0), rd_is(BIN_INDEX_W'(BIN_COUNT - 1), 0),
      px_is(0, 0, 0, 0), px_is(255, 255, 255, 255),
      px(255, 0, 0), px(0, 255, 0), px(0, 0, 255), px(128, 128, 128),
      rd(0), rd(BIN_INDEX_W'(BIN_COUNT - 1)), px(170, 85, 43),
      cf(0, SLIDER_MID), px(255, 255, 255), px_is(0, 0, 0, 0),
      cf(255, SLIDER_MID), px(0, 0, 0), px_is(255, 255, 255, 255),
      cf(SLIDER_MID, 0), px_is(10, 200, 50, 128), px_is(255, 255, 255, 128),
      cf(SLIDER_MID, SLIDER_MAX), px_is(127, 127, 127, 0), px_is(128, 128, 128, 255),
      cf(SLIDER_MID, 255), px_is(128, 128, 128, 255),
      cf(60, 150), px(64, 64, 64), px(200, 100, 50), rd(64), rd(0), rd(100)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.row_kind == ROW_CONFIG) begin
        configure(row.brightness, row.contrast);
      end else begin
        send_beat(row.row_kind == ROW_READ ? CMD_READ : CMD_PIXEL, row.red, row.green,
                  row.blue, row.bin, row.typed, row.result);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      configure(pick_slider(), pick_slider());
      if (phase == 3) begin
        hold_request = 1'b1;
        send_calm = 60;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        idx = BIN_INDEX_W'($urandom);
        case ($urandom_range(0, 7))
          0: begin
            r = 8'($urandom);
            g = r;
            b = r;
          end
          1: begin
            r = {8{1'($urandom)}};
            g = {8{1'($urandom)}};
            b = {8{1'($urandom)}};
          end
          default: begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
          end
        endcase
        send_beat($urandom_range(0, 6) == 0 ? CMD_READ : CMD_PIXEL, r, g, b, idx,
                  1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/gbch_pkg.sv
sv/gbch_div.sv
sv/gbch_hist.sv
sv/gray_brightness_contrast_histogram_unit.sv
tb/gray_brightness_contrast_histogram_unit_tb.sv
